FILE: design/uest_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and point range check for the undirected edge set table
// no dependencies

package uest_pkg;

    localparam int NUM_POINTS = 32;
    localparam int PT_W       = 5;
    localparam int REQ_W      = 3;

    typedef logic [PT_W-1:0]       point_t;
    typedef logic [NUM_POINTS-1:0] row_t;
    typedef logic [REQ_W-1:0]      req_t;

    localparam req_t REQ_ADD      = 3'd0;
    localparam req_t REQ_REMOVE   = 3'd1;
    localparam req_t REQ_TEST     = 3'd2;
    localparam req_t REQ_TRIANGLE = 3'd3;
    localparam req_t REQ_LIST     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINK_FWD,
        ST_LINK_REV,
        ST_TEST,
        ST_SCAN
    } state_t;

    function automatic logic pt_ok(input point_t p);
        pt_ok = ({1'b0, p} < (PT_W+1)'(NUM_POINTS));
    endfunction

endpackage

FILE: design/undirected_edge_set_table_core.sv
`timescale 1ns / 1ps
// undirected edge set table: symmetric adjacency bit matrix with request sequencer
// depends on uest_pkg

// A request is taken when start is high and busy is low. Add and remove update
// the row of each endpoint in turn, forward then reverse; add triangle does so
// for edges ab, ac and bc in order, a test reads a single matrix bit, and a point
// query scans the row bits of the point in ascending order up to the highest set
// bit; unknown request codes finish in the cycle they are taken. Each result shows
// for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take every strobed result. A point query lists edges in
// ascending order of the other point, one per cycle at most, last on the final one.
module undirected_edge_set_table_core
    import uest_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] req_type,
    input  logic [4:0] point_a,
    input  logic [4:0] point_b,
    input  logic [4:0] point_c,
    output logic       result_valid,
    output logic       found,
    output logic       edge_valid,
    output logic [4:0] edge_low,
    output logic [4:0] edge_high,
    output logic       last
);

    state_t      state_reg, state_next;
    req_t        type_reg, type_next;
    point_t      pa_reg, pa_next;
    point_t      pb_reg, pb_next;
    point_t      pc_reg, pc_next;
    logic [1:0]  pair_reg, pair_next;
    row_t        scan_reg, scan_next;
    point_t      idx_reg, idx_next;
    row_t        rows_reg [NUM_POINTS];
    row_t        rows_next [NUM_POINTS];

    logic        res_valid_reg, res_valid_next;
    logic        found_reg, found_next;
    logic        edge_valid_reg, edge_valid_next;
    point_t      edge_low_reg, edge_low_next;
    point_t      edge_high_reg, edge_high_next;
    logic        last_reg, last_next;

    logic        accept;
    point_t      link_x, link_y;
    logic        link_ok;
    logic        link_on;
    logic        pair_done;
    row_t        scan_bit;
    row_t        scan_left;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // triangle edges in order ab, ac, bc
    always_comb
    begin
        case (pair_reg)
            2'd0:
            begin
                link_x = pa_reg;
                link_y = pb_reg;
            end
            2'd1:
            begin
                link_x = pa_reg;
                link_y = pc_reg;
            end
            default:
            begin
                link_x = pb_reg;
                link_y = pc_reg;
            end
        endcase
    end

    assign link_ok   = pt_ok(link_x) && pt_ok(link_y);
    assign link_on   = (type_reg != REQ_REMOVE);
    assign pair_done = (type_reg != REQ_TRIANGLE) || (pair_reg == 2'd2);
    assign scan_bit  = row_t'(1) << idx_reg;
    assign scan_left = scan_reg & ~scan_bit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type) inside
                        REQ_ADD, REQ_REMOVE, REQ_TRIANGLE: state_next = ST_LINK_FWD;
                        REQ_TEST:                          state_next = ST_TEST;
                        REQ_LIST:                          state_next = ST_SCAN;
                        default:                           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LINK_FWD:
                state_next = ST_LINK_REV;
            ST_LINK_REV:
                state_next = pair_done ? ST_IDLE : ST_LINK_FWD;
            ST_TEST:
                state_next = ST_IDLE;
            ST_SCAN:
            begin
                if ((scan_reg == '0) || (scan_reg[idx_reg] && (scan_left == '0)))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb
    begin
        type_next       = type_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        pc_next         = pc_reg;
        pair_next       = pair_reg;
        scan_next       = scan_reg;
        idx_next        = idx_reg;
        rows_next       = rows_reg;
        res_valid_next  = 1'b0;
        found_next      = 1'b0;
        edge_valid_next = 1'b0;
        edge_low_next   = '0;
        edge_high_next  = '0;
        last_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    type_next = req_type;
                    pa_next   = point_a;
                    pb_next   = point_b;
                    pc_next   = point_c;
                    pair_next = 2'd0;
                    idx_next  = '0;
                    scan_next = pt_ok(point_a) ? rows_reg[point_a] : '0;
                    if (!(req_type inside {REQ_ADD, REQ_REMOVE, REQ_TEST,
                                           REQ_TRIANGLE, REQ_LIST}))
                    begin
                        res_valid_next = 1'b1;
                        last_next      = 1'b1;
                    end
                end
            end
            ST_LINK_FWD:
            begin
                if (link_ok)
                begin
                    if (link_on)
                        rows_next[link_x] = rows_reg[link_x] | (row_t'(1) << link_y);
                    else
                        rows_next[link_x] = rows_reg[link_x] & ~(row_t'(1) << link_y);
                end
            end
            ST_LINK_REV:
            begin
                if (link_ok)
                begin
                    if (link_on)
                        rows_next[link_y] = rows_reg[link_y] | (row_t'(1) << link_x);
                    else
                        rows_next[link_y] = rows_reg[link_y] & ~(row_t'(1) << link_x);
                end
                if (pair_done)
                begin
                    res_valid_next = 1'b1;
                    last_next      = 1'b1;
                end
                else
                begin
                    pair_next = pair_reg + 2'd1;
                end
            end
            ST_TEST:
            begin
                res_valid_next = 1'b1;
                last_next      = 1'b1;
                found_next     = pt_ok(pa_reg) && pt_ok(pb_reg) && rows_reg[pa_reg][pb_reg];
            end
            ST_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    last_next      = 1'b1;
                end
                else
                begin
                    if (scan_reg[idx_reg])
                    begin
                        res_valid_next  = 1'b1;
                        edge_valid_next = 1'b1;
                        edge_low_next   = (idx_reg < pa_reg) ? idx_reg : pa_reg;
                        edge_high_next  = (idx_reg < pa_reg) ? pa_reg : idx_reg;
                        last_next       = (scan_left == '0);
                        scan_next       = scan_left;
                    end
                    idx_next = idx_reg + point_t'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            rows_reg      <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        pc_reg         <= pc_next;
        pair_reg       <= pair_next;
        scan_reg       <= scan_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        edge_valid_reg <= edge_valid_next;
        edge_low_reg   <= edge_low_next;
        edge_high_reg  <= edge_high_next;
        last_reg       <= last_next;
    end

    assign result_valid = res_valid_reg;
    assign found        = found_reg;
    assign edge_valid   = edge_valid_reg;
    assign edge_low     = edge_low_reg;
    assign edge_high    = edge_high_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_found_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && found) |-> (last && !edge_valid))
        else $error("found flag on a non-final or listed result");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && edge_valid) |-> (edge_low <= edge_high))
        else $error("listed edge endpoints out of order");

    a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last && (state_reg == ST_IDLE)
            && pt_ok(pa_reg) && pt_ok(pb_reg))
        |-> (rows_reg[pa_reg][pb_reg] == rows_reg[pb_reg][pa_reg]))
        else $error("adjacency matrix lost symmetry");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_IDLE) |=> (result_valid && last))
        else $error("point query ended without a final result");

    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK_FWD) |=> !result_valid)
        else $error("result strobe during first half of an edge update");
`endif

endmodule

FILE: tb/sv/tb_undirected_edge_set_table_core.sv
`timescale 1ns / 1ps
// self-checking testbench for undirected_edge_set_table_core: directed and random requests
// with a scoreboard that keeps its own adjacency matrix; depends on uest_pkg and the core

module tb_undirected_edge_set_table_core
    import uest_pkg::*;
();

    localparam req_t REQ_RSVD5   = 3'd5;
    localparam req_t REQ_RSVD6   = 3'd6;
    localparam req_t REQ_RSVD7   = 3'd7;
    localparam int RANDOM_ITEMS  = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 13;

    typedef struct packed {
        logic   found;
        logic   edge_valid;
        point_t edge_low;
        point_t edge_high;
        logic   last;
    } edge_result_t;

    class edge_set_scoreboard;
        row_t         rows [NUM_POINTS];
        edge_result_t expected_results [$];
        int           errors;

        function new();
            errors = 0;
            foreach (rows[i])
                rows[i] = '0;
        endfunction

        function bit point_exists(point_t p);
            return int'(p) < NUM_POINTS;
        endfunction

        function void set_link(point_t a, point_t b, logic on);
            if (point_exists(a) && point_exists(b))
            begin
                rows[a][b] = on;
                rows[b][a] = on;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void add_expected(edge_result_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_request(req_t kind, point_t a, point_t b, point_t c);
            edge_result_t res;
            row_t         row;
            res      = '0;
            res.last = 1'b1;
            if (kind == REQ_LIST)
            begin
                row = point_exists(a) ? rows[a] : '0;
                if (row == '0)
                    add_expected(res);
                for (int j = 0; j < NUM_POINTS; j++)
                begin
                    if (row[j])
                    begin
                        res.edge_valid = 1'b1;
                        res.edge_low   = (point_t'(j) < a) ? point_t'(j) : a;
                        res.edge_high  = (point_t'(j) < a) ? a : point_t'(j);
                        res.last       = ((row >> (j + 1)) == '0);
                        add_expected(res);
                    end
                end
            end
            else
            begin
                case (kind)
                    REQ_ADD:    set_link(a, b, 1'b1);
                    REQ_REMOVE: set_link(a, b, 1'b0);
                    REQ_TEST:
                        res.found = (point_exists(a) && point_exists(b)) ? rows[a][b] : 1'b0;
                    REQ_TRIANGLE:
                    begin
                        set_link(a, b, 1'b1);
                        set_link(a, c, 1'b1);
                        set_link(b, c, 1'b1);
                    end
                    default: ;
                endcase
                add_expected(res);
            end
        endfunction

        function void check_result(logic fnd, logic ev, point_t lo, point_t hi, logic lst);
            edge_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error({"unexpected result transfer: found %0d edge_valid %0d",
                        " low %0d high %0d last %0d"}, fnd, ev, lo, hi, lst);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (fnd !== exp_res.found)
            begin
                $error("found mismatch: expected %0d, actual %0d", exp_res.found, fnd);
                errors++;
            end
            if (ev !== exp_res.edge_valid)
            begin
                $error("edge_valid mismatch: expected %0d, actual %0d", exp_res.edge_valid, ev);
                errors++;
            end
            if (lo !== exp_res.edge_low)
            begin
                $error("edge_low mismatch: expected %0d, actual %0d", exp_res.edge_low, lo);
                errors++;
            end
            if (hi !== exp_res.edge_high)
            begin
                $error("edge_high mismatch: expected %0d, actual %0d", exp_res.edge_high, hi);
                errors++;
            end
            if (lst !== exp_res.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", exp_res.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   start      = 1'b0;
    req_t   req_type   = '0;
    point_t point_a    = '0;
    point_t point_b    = '0;
    point_t point_c    = '0;
    logic   busy;
    logic   result_valid;
    logic   found;
    logic   edge_valid;
    point_t edge_low;
    point_t edge_high;
    logic   last;

    bit     no_gaps     = 1'b0;
    int     idle_cycles = 0;

    edge_set_scoreboard sb = new();

    undirected_edge_set_table_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .point_a      (point_a),
        .point_b      (point_b),
        .point_c      (point_c),
        .result_valid (result_valid),
        .found        (found),
        .edge_valid   (edge_valid),
        .edge_low     (edge_low),
        .edge_high    (edge_high),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // request and result monitor, stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req_type, point_a, point_b, point_c);
            if (result_valid)
                sb.check_result(found, edge_valid, edge_low, edge_high, last);
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(input req_t kind, input point_t a, input point_t b,
                                input point_t c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        point_a  <= a;
        point_b  <= b;
        point_c  <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        req_t   kind;
        point_t hub;
        point_t pts [3];
        int     pick;

        hub = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, self-loops, repeats, absent removes, empty queries
        send_request(REQ_ADD,      5'd0,  5'd31, 5'd0);
        send_request(REQ_ADD,      5'd31, 5'd31, 5'd31);
        send_request(REQ_ADD,      5'd0,  5'd31, 5'd17);
        send_request(REQ_TEST,     5'd31, 5'd0,  5'd0);
        send_request(REQ_TEST,     5'd0,  5'd0,  5'd31);
        send_request(REQ_LIST,     5'd0,  5'd0,  5'd0);
        send_request(REQ_LIST,     5'd31, 5'd31, 5'd31);
        send_request(REQ_REMOVE,   5'd5,  5'd6,  5'd0);
        send_request(REQ_TRIANGLE, 5'd10, 5'd21, 5'd31);
        send_request(REQ_TRIANGLE, 5'd7,  5'd7,  5'd7);
        send_request(REQ_TRIANGLE, 5'd3,  5'd3,  5'd12);
        send_request(REQ_LIST,     5'd3,  5'd0,  5'd0);
        send_request(REQ_LIST,     5'd9,  5'd31, 5'd31);
        send_request(REQ_LIST,     5'd31, 5'd0,  5'd0);
        send_request(REQ_REMOVE,   5'd31, 5'd0,  5'd0);
        send_request(REQ_TEST,     5'd0,  5'd31, 5'd0);
        send_request(REQ_LIST,     5'd0,  5'd0,  5'd0);
        send_request(REQ_REMOVE,   5'd31, 5'd31, 5'd0);
        send_request(REQ_TEST,     5'd21, 5'd10, 5'd0);
        send_request(REQ_RSVD5,    5'd31, 5'd31, 5'd31);
        send_request(REQ_RSVD6,    5'd0,  5'd0,  5'd0);
        send_request(REQ_RSVD7,    5'd31, 5'd31, 5'd31);
        send_request(REQ_TRIANGLE, 5'd31, 5'd0,  5'd16);
        send_request(REQ_LIST,     5'd16, 5'd0,  5'd0);
        send_request(REQ_LIST,     5'd31, 5'd0,  5'd0);
        drain_results();

        // random: requests cluster around a moving hub so that rows fill up
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                hub     = point_t'($urandom);
            end
            if ($urandom_range(0, 59) == 0)
                drain_results();
            for (int k = 0; k < 3; k++)
                pts[k] = ($urandom_range(0, 3) == 0) ? point_t'($urandom)
                                                    : point_t'(hub + $urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                kind = REQ_ADD;
            else if (pick < 40)
                kind = REQ_TRIANGLE;
            else if (pick < 55)
                kind = REQ_REMOVE;
            else if (pick < 72)
                kind = REQ_TEST;
            else if (pick < 95)
                kind = REQ_LIST;
            else
                kind = req_t'($urandom_range(REQ_RSVD5, REQ_RSVD7));
            send_request(kind, pts[0], pts[1], pts[2]);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/uest_pkg.sv
design/undirected_edge_set_table_core.sv
tb/sv/tb_undirected_edge_set_table_core.sv
